// ===== src/pbsr_pkg.sv =====
package pbsr_pkg;

  localparam int PBSR_QUEUE_DEPTH = 2;
  localparam int DIV_STEPS = 16;
  localparam int NUM_W = 66;
  localparam int DEN_W = 50;

  typedef enum logic [2:0] {
    REG_ROW0   = 3'd0,
    REG_ROW1   = 3'd1,
    REG_ROW2   = 3'd2,
    REG_ROW3   = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5
  } reg_idx_t;

  localparam logic [63:0] ROW0_RST = 64'd4096;
  localparam logic [63:0] ROW1_RST = 64'd268435456;
  localparam logic [63:0] ROW2_RST = 64'd17592186044416;
  localparam logic [63:0] ROW3_RST = 64'd1152921504606846976;
  localparam logic [11:0] WIDTH_RST = 12'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;

  typedef struct packed {
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } in_t;

  typedef struct packed {
    logic        on_screen;
    logic [15:0] rect_min_x;
    logic [15:0] rect_min_y;
    logic [15:0] rect_max_x;
    logic [15:0] rect_max_y;
  } out_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic             vis;
    logic [NUM_W-1:0] rx;
    logic [NUM_W-1:0] ry;
    logic [DEN_W-1:0] w;
    logic [15:0]      qx;
    logic [15:0]      qy;
  } div_t;

endpackage

// ===== src/pbsr_queue.sv =====
module pbsr_queue
  import pbsr_pkg::*;
#(
  parameter int DEPTH = PBSR_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  in_t  push_data,
  input  logic pop,
  output in_t  head,
  output logic avail,
  output logic full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  in_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign avail = count != '0;
  assign full  = count == CW'(DEPTH);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/pbsr_xform.sv =====
module pbsr_xform
  import pbsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  in_t              head,
  input  logic             avail,
  output logic             pop,
  input  logic [3:0][63:0] matrix,
  input  logic [11:0]      screen_width,
  input  logic [11:0]      screen_height,
  output div_t             corner
);

  logic [2:0] idx;
  logic signed [31:0] px, py, pz;
  logic signed [15:0] m [4][4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        m[i][j] = matrix[i][16*j +: 16];
      end
    end
  end

  assign px  = idx[0] ? head.box_max_x : head.box_min_x;
  assign py  = idx[1] ? head.box_max_y : head.box_min_y;
  assign pz  = idx[2] ? head.box_max_z : head.box_min_z;
  assign pop = avail && (idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (avail) begin
      idx <= idx + 1'b1;
    end
  end

  // products, columns x y w
  logic s1_valid, s1_last;
  logic signed [47:0] pr [3][3];
  logic signed [15:0] m3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= avail;
    end
  end

  always_ff @(posedge clk) begin
    s1_last <= idx == 3'd7;
    for (int k = 0; k < 3; k++) begin
      pr[0][k] <= px * m[0][(k == 2) ? 3 : k];
      pr[1][k] <= py * m[1][(k == 2) ? 3 : k];
      pr[2][k] <= pz * m[2][(k == 2) ? 3 : k];
      m3[k]    <= m[3][(k == 2) ? 3 : k];
    end
  end

  // clip sums
  logic s2_valid, s2_last;
  logic signed [50:0] cx, cy, cw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_last <= s1_last;
    cx <= 51'(pr[0][0]) + 51'(pr[1][0]) + 51'(pr[2][0]) + (51'(m3[0]) <<< 28);
    cy <= 51'(pr[0][1]) + 51'(pr[1][1]) + 51'(pr[2][1]) + (51'(m3[1]) <<< 28);
    cw <= 51'(pr[0][2]) + 51'(pr[1][2]) + 51'(pr[2][2]) + (51'(m3[2]) <<< 28);
  end

  // numerators and range classes
  logic s3_valid, s3_last, s3_vis;
  logic s3_zx, s3_sx, s3_zy, s3_sy;
  logic [50:0] s3_nx, s3_ny;
  logic [DEN_W-1:0] s3_w;
  logic signed [51:0] nx, ny, w2;

  assign nx = 52'(cx) + 52'(cw);
  assign ny = 52'(cw) - 52'(cy);
  assign w2 = 52'(cw) <<< 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_last <= s2_last;
    s3_vis  <= cw > 51'sd0;
    s3_zx   <= nx <= 52'sd0;
    s3_sx   <= nx >= w2;
    s3_zy   <= ny <= 52'sd0;
    s3_sy   <= ny >= w2;
    s3_nx   <= nx[50:0];
    s3_ny   <= ny[50:0];
    s3_w    <= cw[DEN_W-1:0];
  end

  // scale by size, set up the division
  logic [62:0] mx, my;

  assign mx = s3_nx * screen_width;
  assign my = s3_ny * screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner.valid <= 1'b0;
    end else begin
      corner.valid <= s3_valid;
    end
    corner.last <= s3_last;
    corner.vis  <= s3_vis;
    corner.w    <= s3_w;
    corner.rx   <= (s3_zx || s3_sx) ? '0 : {mx, 3'b000};
    corner.ry   <= (s3_zy || s3_sy) ? '0 : {my, 3'b000};
    corner.qx   <= (s3_sx && !s3_zx) ? {screen_width, 4'b0000} : '0;
    corner.qy   <= (s3_sy && !s3_zy) ? {screen_height, 4'b0000} : '0;
  end

endmodule

// ===== src/pbsr_div.sv =====
module pbsr_div
  import pbsr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  div_t din,
  output div_t dout
);

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    localparam int K = DIV_STEPS - 1 - s;
    div_t             cur;
    div_t             stage;
    logic [NUM_W-1:0] dsh;
    logic             gx, gy;

    if (s == 0) begin : g_first
      assign cur = din;
    end else begin : g_next
      assign cur = g_step[s-1].stage;
    end

    assign dsh = NUM_W'(cur.w) << K;
    assign gx  = cur.rx >= dsh;
    assign gy  = cur.ry >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        stage.valid <= 1'b0;
      end else begin
        stage.valid <= cur.valid;
      end
      stage.last <= cur.last;
      stage.vis  <= cur.vis;
      stage.w    <= cur.w;
      stage.rx   <= gx ? cur.rx - dsh : cur.rx;
      stage.ry   <= gy ? cur.ry - dsh : cur.ry;
      stage.qx   <= cur.qx | (16'(gx) << K);
      stage.qy   <= cur.qy | (16'(gy) << K);
    end
  end

  assign dout = g_step[DIV_STEPS-1].stage;

endmodule

// ===== src/project_box_to_screen_rect.sv =====
// channel  | strobe / hold   | payload
// ---------+-----------------+---------------------------------
// box in   | start, busy     | box    (in_t, six Q16.16 bounds)
// result   | done            | result (out_t, flag and Q12.4 rect)
// config   | wr_en           | wr_index, wr_data
//
// the corner sequencer walks each queued box's eight corners, one per cycle
// while a box is queued, through the shared transform and divide pipeline
// done strobes after an item's last corner clears the divider; items overlap
// busy is high while the two-entry input queue is full; done cannot be held off
// rst is synchronous; registers return to identity matrix and 640x480
module project_box_to_screen_rect
  import pbsr_pkg::*;
#(
  parameter int QUEUE_DEPTH = PBSR_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_t         box,
  output logic        done,
  output out_t        result,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [63:0] wr_data
);

  logic [3:0][63:0] matrix;
  logic [11:0]      screen_width, screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix        <= {ROW3_RST, ROW2_RST, ROW1_RST, ROW0_RST};
      screen_width  <= WIDTH_RST;
      screen_height <= HEIGHT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_ROW0:   matrix[0] <= wr_data;
        REG_ROW1:   matrix[1] <= wr_data;
        REG_ROW2:   matrix[2] <= wr_data;
        REG_ROW3:   matrix[3] <= wr_data;
        REG_WIDTH:  screen_width <= wr_data[11:0];
        REG_HEIGHT: screen_height <= wr_data[11:0];
        default: ;
      endcase
    end
  end

  in_t  head;
  logic avail, full, pop;
  div_t corner, quot;

  assign busy = full;

  pbsr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (start && !full),
    .push_data (box),
    .pop       (pop),
    .head      (head),
    .avail     (avail),
    .full      (full)
  );

  pbsr_xform u_xform (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .avail         (avail),
    .pop           (pop),
    .matrix        (matrix),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .corner        (corner)
  );

  pbsr_div u_div (
    .clk  (clk),
    .rst  (rst),
    .din  (corner),
    .dout (quot)
  );

  // running bounds over the item's corners
  logic        any, any_next;
  logic [15:0] mnx, mny, mxx, mxy;
  logic [15:0] mnx_next, mny_next, mxx_next, mxy_next;

  always_comb begin
    any_next = any;
    mnx_next = mnx;
    mny_next = mny;
    mxx_next = mxx;
    mxy_next = mxy;
    if (quot.vis) begin
      any_next = 1'b1;
      if (!any) begin
        mnx_next = quot.qx;
        mxx_next = quot.qx;
        mny_next = quot.qy;
        mxy_next = quot.qy;
      end else begin
        mnx_next = (quot.qx < mnx) ? quot.qx : mnx;
        mxx_next = (quot.qx > mxx) ? quot.qx : mxx;
        mny_next = (quot.qy < mny) ? quot.qy : mny;
        mxy_next = (quot.qy > mxy) ? quot.qy : mxy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= quot.valid && quot.last;
      if (quot.valid) begin
        any <= quot.last ? 1'b0 : any_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (quot.valid) begin
      mnx <= mnx_next;
      mny <= mny_next;
      mxx <= mxx_next;
      mxy <= mxy_next;
    end
    if (quot.valid && quot.last) begin
      result.on_screen  <= any_next;
      result.rect_min_x <= any_next ? mnx_next : '0;
      result.rect_min_y <= any_next ? mny_next : '0;
      result.rect_max_x <= any_next ? mxx_next : '0;
      result.rect_max_y <= any_next ? mxy_next : '0;
    end
  end

endmodule

// ===== verif/tb_project_box_to_screen_rect.sv =====
module tb_project_box_to_screen_rect;
  import pbsr_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_t         box;
  logic        done;
  out_t        result;
  logic        wr_en;
  logic [2:0]  wr_index;
  logic [63:0] wr_data;

  project_box_to_screen_rect u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .box(box),
    .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  logic [63:0] mat_rows [4];
  logic [11:0] scr_w, scr_h;

  in_t  pending_boxes [$];
  out_t expected_rects [$];

  int errors = 0;
  int rects_seen = 0;
  int visible_seen = 0;
  int boxes_sent = 0;
  longint cycles = 0;
  bit  hold_off = 1'b0;
  bit  box_taken = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d (rect %0d)", what, got, want, rects_seen);
    errors++;
  endtask

  task automatic add_box(input in_t b);
    pending_boxes.insert(pending_boxes.size(), b);
  endtask

  function automatic longint coeff(input int r, input int c);
    logic signed [15:0] f;
    f = mat_rows[r][16*c +: 16];
    return longint'(f);
  endfunction

  function automatic longint map_axis(input longint num, input longint w,
                                      input logic [11:0] size);
    logic [127:0] p;
    if (num <= 0) return 0;
    if (num >= 2 * w) return longint'(size) * 16;
    p = 128'(num) * 128'(size) * 128'd8;
    return longint'(p / 128'(w));
  endfunction

  function automatic out_t screen_rect(input in_t b);
    out_t   r;
    longint lo [3], hi [3], p [3], clip [4];
    longint sx, sy, mnx, mny, mxx, mxy;
    bit     any;
    mnx = 0; mny = 0; mxx = 0; mxy = 0; any = 0;
    lo[0] = b.box_min_x; lo[1] = b.box_min_y; lo[2] = b.box_min_z;
    hi[0] = b.box_max_x; hi[1] = b.box_max_y; hi[2] = b.box_max_z;
    for (int c = 0; c < 8; c++) begin
      p[0] = c[0] ? hi[0] : lo[0];
      p[1] = c[1] ? hi[1] : lo[1];
      p[2] = c[2] ? hi[2] : lo[2];
      for (int j = 0; j < 4; j++)
        clip[j] = p[0] * coeff(0, j) + p[1] * coeff(1, j) + p[2] * coeff(2, j)
                + coeff(3, j) * (64'sd1 << 28);
      if (clip[3] <= 0) continue;
      sx = map_axis(clip[0] + clip[3], clip[3], scr_w);
      sy = map_axis(clip[3] - clip[1], clip[3], scr_h);
      if (!any) begin
        mnx = sx; mxx = sx; mny = sy; mxy = sy; any = 1;
      end else begin
        if (sx < mnx) mnx = sx;
        if (sx > mxx) mxx = sx;
        if (sy < mny) mny = sy;
        if (sy > mxy) mxy = sy;
      end
    end
    r.on_screen  = any;
    r.rect_min_x = mnx[15:0];
    r.rect_min_y = mny[15:0];
    r.rect_max_x = mxx[15:0];
    r.rect_max_y = mxy[15:0];
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (box_taken) begin
      boxes_sent++;
      expected_rects.insert(expected_rects.size(), screen_rect(box));
      void'(pending_boxes.pop_front());
      if (pending_boxes.size() > 0 && burst_left > 0 && !hold_off) begin
        box <= pending_boxes[0];
        burst_left--;
      end else begin
        start <= 1'b0;
        gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : $urandom_range(0, 2);
      end
    end else if (!start && !hold_off && pending_boxes.size() > 0) begin
      if (gap_left > 0) begin
        gap_left--;
      end else begin
        box <= pending_boxes[0];
        start <= 1'b1;
        burst_left = $urandom_range(0, 12);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    box_taken = !rst && start && !busy;
    if (!rst && done) begin
      out_t want;
      rects_seen++;
      if (expected_rects.size() == 0) begin
        $display("unexpected result beat %0d", rects_seen);
        errors++;
      end else begin
        want = expected_rects.pop_front();
        if (result.on_screen !== want.on_screen)
          report("on_screen", longint'(result.on_screen), longint'(want.on_screen));
        if (result.rect_min_x !== want.rect_min_x)
          report("rect_min_x", longint'(result.rect_min_x), longint'(want.rect_min_x));
        if (result.rect_min_y !== want.rect_min_y)
          report("rect_min_y", longint'(result.rect_min_y), longint'(want.rect_min_y));
        if (result.rect_max_x !== want.rect_max_x)
          report("rect_max_x", longint'(result.rect_max_x), longint'(want.rect_max_x));
        if (result.rect_max_y !== want.rect_max_y)
          report("rect_max_y", longint'(result.rect_max_y), longint'(want.rect_max_y));
        if (want.on_screen) visible_seen++;
      end
    end
    if (cycles > 400000) begin
      $display("tb_project_box_to_screen_rect NOT OK");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    case (idx)
      REG_ROW0:   mat_rows[0] = val;
      REG_ROW1:   mat_rows[1] = val;
      REG_ROW2:   mat_rows[2] = val;
      REG_ROW3:   mat_rows[3] = val;
      REG_WIDTH:  scr_w = val[11:0];
      REG_HEIGHT: scr_h = val[11:0];
      default: ;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_boxes.size() == 0 && !start && expected_rects.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'h1000;
      default: return 16'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  function automatic logic [63:0] rand_row();
    return {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 2 * 65536 * 4)) - 65536 * 4);
      3: return $urandom;
      default: return 32'($signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64);
    endcase
  endfunction

  function automatic in_t rand_box();
    in_t b;
    b.box_min_x = rand_coord(); b.box_min_y = rand_coord(); b.box_min_z = rand_coord();
    b.box_max_x = rand_coord(); b.box_max_y = rand_coord(); b.box_max_z = rand_coord();
    // mostly ordered boxes, some left inverted
    if ($urandom_range(0, 4) != 0) begin
      if (b.box_min_x > b.box_max_x) {b.box_min_x, b.box_max_x} = {b.box_max_x, b.box_min_x};
      if (b.box_min_y > b.box_max_y) {b.box_min_y, b.box_max_y} = {b.box_max_y, b.box_min_y};
      if (b.box_min_z > b.box_max_z) {b.box_min_z, b.box_max_z} = {b.box_max_z, b.box_min_z};
    end
    return b;
  endfunction

  function automatic in_t mk_box(input int x0, y0, z0, x1, y1, z1);
    in_t b;
    b.box_min_x = x0; b.box_min_y = y0; b.box_min_z = z0;
    b.box_max_x = x1; b.box_max_y = y1; b.box_max_z = z1;
    return b;
  endfunction

  // simple perspective: w = z, so boxes with positive z stay in front
  localparam logic [63:0] PERSP_ROW2 = 64'h1000_0000_0000_0000;
  localparam logic [63:0] PERSP_ROW3 = 64'h0000_0000_0000_0000;

  initial begin
    rst = 1'b1; start = 1'b0; box = '0;
    wr_en = 1'b0; wr_index = REG_ROW0; wr_data = '0;
    mat_rows[0] = ROW0_RST; mat_rows[1] = ROW1_RST;
    mat_rows[2] = ROW2_RST; mat_rows[3] = ROW3_RST;
    scr_w = WIDTH_RST; scr_h = HEIGHT_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, identity matrix at reset
    add_box(mk_box(0, 0, 0, 0, 0, 0));
    add_box(mk_box(-32768, -32768, 0, 32768, 32768, 0));
    add_box(mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    add_box(mk_box(65536, 65536, 0, -65536, -65536, 0));
    add_box(mk_box(-1, -1, -1, -1, -1, -1));
    add_box(mk_box(-200000, 100, 5, -100000, 200000, 7));
    drain();

    // nothing in front: w = 0
    write_reg(REG_ROW3, 64'd0);
    add_box(mk_box(-65536, -65536, -65536, 65536, 65536, 65536));
    drain();
    // perspective, boxes in front of, straddling and behind the camera plane
    write_reg(REG_ROW2, PERSP_ROW2);
    write_reg(REG_ROW3, PERSP_ROW3);
    add_box(mk_box(-65536, -65536, 65536, 65536, 65536, 3 * 65536));
    add_box(mk_box(-65536, -65536, -65536, 65536, 65536, 65536));
    add_box(mk_box(-65536, -65536, -3 * 65536, 65536, 65536, -65536));
    add_box(mk_box(32'h8000_0000, 32'h8000_0000, 1,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    drain();
    // zero and maximum screen sizes
    write_reg(REG_WIDTH, 64'd0);
    write_reg(REG_HEIGHT, 64'd4095);
    add_box(mk_box(-30000, -30000, 65536, 30000, 30000, 2 * 65536));
    drain();
    write_reg(REG_WIDTH, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_HEIGHT, 64'd0);
    add_box(mk_box(-30000, -30000, 65536, 30000, 30000, 2 * 65536));
    drain();

    // random phases
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) begin
        write_reg(REG_ROW0, 64'hffff_ffff_ffff_ffff);
        write_reg(REG_ROW1, 64'h8000_8000_8000_8000);
        write_reg(REG_ROW2, 64'h7fff_7fff_7fff_7fff);
        write_reg(REG_ROW3, 64'h7fff_7fff_7fff_7fff);
        write_reg(REG_WIDTH, 64'd1);
        write_reg(REG_HEIGHT, 64'd1);
      end else if (ph < 5) begin
        write_reg(REG_ROW0, ROW0_RST);
        write_reg(REG_ROW1, ROW1_RST);
        write_reg(REG_ROW2, $urandom_range(0, 1) ? PERSP_ROW2 : ROW2_RST);
        write_reg(REG_ROW3, $urandom_range(0, 1) ? PERSP_ROW3 : rand_row());
        write_reg(REG_WIDTH, 64'($urandom_range(1, 4095)));
        write_reg(REG_HEIGHT, 64'($urandom_range(1, 4095)));
      end else begin
        write_reg(REG_ROW0, rand_row());
        write_reg(REG_ROW1, rand_row());
        write_reg(REG_ROW2, rand_row());
        write_reg(REG_ROW3, rand_row());
        write_reg(REG_WIDTH, 64'($urandom_range(0, 4095)));
        write_reg(REG_HEIGHT, 64'($urandom_range(0, 4095)));
      end
      for (int k = 0; k < 45; k++) add_box(rand_box());
      if (ph == 3) begin
        wait (pending_boxes.size() < 20);
        @(negedge clk);
        hold_off = 1'b1;
        wait (!start && expected_rects.size() == 0);
        repeat (30) @(posedge clk);
        @(negedge clk);
        hold_off = 1'b0;
      end
      drain();
    end

    $display("boxes sent %0d, results checked %0d, %0d of them on screen",
             boxes_sent, rects_seen, visible_seen);
    $display("covered reset identity, perspective, zero and extreme matrices and screen sizes");
    if (errors == 0 && expected_rects.size() == 0)
      $display("tb_project_box_to_screen_rect OK");
    else
      $display("tb_project_box_to_screen_rect NOT OK");
    $finish;
  end

endmodule
